// ===== design/sddl_pkg.sv =====
// sddl_pkg: shared types and constants of the switchable depth delay line
// no dependencies; used by switchable_depth_delay_line
package sddl_pkg;

    localparam int WORD_BITS  = 64;
    localparam int DEPTH_BITS = 9;
    // ring capacity in records, a power of two so that slot arithmetic wraps
    localparam int MAX_DEPTH  = 256;
    localparam int IDX_W      = $clog2(MAX_DEPTH);
    localparam int CNT_W      = $clog2(MAX_DEPTH + 1);

    localparam logic OP_SAMPLE   = 1'b0;
    localparam logic OP_PRIORITY = 1'b1;

    typedef struct packed {
        logic [WORD_BITS-1:0] position;
        logic [WORD_BITS-1:0] velocity;
        logic [WORD_BITS-1:0] effort;
    } record_t;

    typedef enum logic [2:0] {
        SRC_MEM  = 3'b001,
        SRC_WORD = 3'b010,
        SRC_ZERO = 3'b100
    } src_sel_t;

endpackage

// ===== design/switchable_depth_delay_line.sv =====
// switchable_depth_delay_line: programmable delay line for three-word records
// depends on sddl_pkg (record type, ring sizes, operation and source codes)
//
// Takes one item per clock and returns one result per data sample; the ring read lands
// in its register when the item is accepted, and the output register loads from it
// once the output stage is free. A full output stage with m_ready low stalls the input.
// Priority messages give no result. A depth of zero passes samples straight through
// the same read stage and output register. The 256-record ring sits in one read-first
// memory that is read and written at the same edge an item is accepted, so consecutive
// items need no forwarding. Records not written since the last depth write read as zero
// through per-slot valid flags, and padding after a return to normal latency lives in a
// pad segment register instead of being written into the ring, so a grow does not hold
// off the input. Depth writes take effect at once and need no clearing pass.
module switchable_depth_delay_line (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wr_en,
    input  logic [sddl_pkg::DEPTH_BITS-1:0]   cfg_wr_data,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic                              s_operation,
    input  logic                              s_relaxed_priority,
    input  logic [sddl_pkg::WORD_BITS-1:0]    s_position_word,
    input  logic [sddl_pkg::WORD_BITS-1:0]    s_velocity_word,
    input  logic [sddl_pkg::WORD_BITS-1:0]    s_effort_word,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [sddl_pkg::WORD_BITS-1:0]    m_delayed_position,
    output logic [sddl_pkg::WORD_BITS-1:0]    m_delayed_velocity,
    output logic [sddl_pkg::WORD_BITS-1:0]    m_delayed_effort
);

    // ring memory
    sddl_pkg::record_t ring_mem [sddl_pkg::MAX_DEPTH];
    sddl_pkg::record_t rd_data_reg;

    // control state
    logic [sddl_pkg::DEPTH_BITS-1:0] depth_reg, depth_next;
    logic [sddl_pkg::IDX_W-1:0]      oldest_reg, oldest_next;
    logic [sddl_pkg::CNT_W-1:0]      count_reg, count_next;
    logic                            low_lat_reg, low_lat_next;
    logic                            shrink_reg, shrink_next;
    logic                            grow_reg, grow_next;
    logic [sddl_pkg::MAX_DEPTH-1:0]  slot_valid_reg, slot_valid_next;
    logic [sddl_pkg::IDX_W-1:0]      pad_start_reg, pad_start_next;
    logic [sddl_pkg::CNT_W-1:0]      pad_len_reg, pad_len_next;
    sddl_pkg::record_t               pad_rec_reg, pad_rec_next;

    // read stage and output register
    logic                  s1_valid_reg, s1_valid_next;
    sddl_pkg::src_sel_t    s1_src_reg, s1_src_next;
    sddl_pkg::record_t     s1_word_reg, s1_word_next;
    logic                  m_valid_reg, m_valid_next;
    sddl_pkg::record_t     m_rec_reg, m_rec_next;

    sddl_pkg::record_t s_rec;
    sddl_pkg::record_t s1_rec;
    logic s_accept, sample_go, s1_move, out_free;
    logic mem_rd_en, mem_wr_en;
    logic [sddl_pkg::IDX_W-1:0] mem_rd_addr, mem_wr_addr;

    // per-sample working values
    logic                       shrink_go, grow_go, pad_hit;
    logic [sddl_pkg::IDX_W-1:0] oldest_a, pad_start_b;
    logic [sddl_pkg::CNT_W-1:0] count_a, count_b, pad_len_a, pad_len_b, depth_sat;
    sddl_pkg::record_t          pad_rec_b;

    assign s_rec    = '{position: s_position_word, velocity: s_velocity_word,
                        effort: s_effort_word};
    assign out_free = !m_valid_reg || m_ready;
    assign s1_move  = s1_valid_reg && out_free;
    assign s_ready  = !s1_valid_reg || s1_move;
    assign s_accept = s_valid && s_ready;
    assign sample_go = s_accept && (s_operation == sddl_pkg::OP_SAMPLE)
                       && (depth_reg != '0);

    always_comb begin
        case (s1_src_reg)
            sddl_pkg::SRC_MEM:  s1_rec = rd_data_reg;
            sddl_pkg::SRC_WORD: s1_rec = s1_word_reg;
            sddl_pkg::SRC_ZERO: s1_rec = '0;
            default:            s1_rec = '0;
        endcase
    end

    always_comb begin
        if (cfg_wr_data > sddl_pkg::DEPTH_BITS'(sddl_pkg::MAX_DEPTH)) begin
            depth_sat = sddl_pkg::CNT_W'(sddl_pkg::MAX_DEPTH);
        end else begin
            depth_sat = sddl_pkg::CNT_W'(cfg_wr_data);
        end
    end

    // shrink, grow, front read and back write of one sample
    always_comb begin
        shrink_go = shrink_reg && (count_reg > sddl_pkg::CNT_W'(1));
        if (shrink_go) begin
            oldest_a  = oldest_reg + sddl_pkg::IDX_W'(count_reg - sddl_pkg::CNT_W'(1));
            count_a   = sddl_pkg::CNT_W'(1);
            pad_len_a = '0;
        end else begin
            oldest_a  = oldest_reg;
            count_a   = count_reg;
            pad_len_a = pad_len_reg;
        end
        grow_go = grow_reg && (count_a < sddl_pkg::CNT_W'(depth_reg));
        if (grow_go) begin
            pad_start_b = oldest_a + sddl_pkg::IDX_W'(count_a);
            pad_len_b   = sddl_pkg::CNT_W'(depth_reg) - count_a;
            pad_rec_b   = s_rec;
        end else begin
            pad_start_b = pad_start_reg;
            pad_len_b   = pad_len_a;
            pad_rec_b   = pad_rec_reg;
        end
        count_b = grow_reg ? sddl_pkg::CNT_W'(depth_reg) : count_a;
        // the pad segment is always the tail of the live records, so it is hit
        // only when its first slot reaches the front
        pad_hit = (pad_len_b != '0) && (pad_start_b == oldest_a);
        mem_rd_addr = oldest_a;
        mem_wr_addr = oldest_a + sddl_pkg::IDX_W'(count_b);
    end

    always_comb begin
        depth_next      = depth_reg;
        oldest_next     = oldest_reg;
        count_next      = count_reg;
        low_lat_next    = low_lat_reg;
        shrink_next     = shrink_reg;
        grow_next       = grow_reg;
        slot_valid_next = slot_valid_reg;
        pad_start_next  = pad_start_reg;
        pad_len_next    = pad_len_reg;
        pad_rec_next    = pad_rec_reg;
        s1_valid_next   = s1_move ? 1'b0 : s1_valid_reg;
        s1_src_next     = s1_src_reg;
        s1_word_next    = s1_word_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        m_rec_next      = m_rec_reg;
        mem_rd_en       = 1'b0;
        mem_wr_en       = 1'b0;

        if (s1_move) begin
            m_valid_next = 1'b1;
            m_rec_next   = s1_rec;
        end

        if (cfg_wr_en) begin
            depth_next      = depth_sat;
            oldest_next     = '0;
            count_next      = depth_sat;
            slot_valid_next = '0;
            pad_len_next    = '0;
        end else if (s_accept && (s_operation == sddl_pkg::OP_PRIORITY)) begin
            low_lat_next = !s_relaxed_priority;
            if (!low_lat_reg && !s_relaxed_priority) begin
                shrink_next = 1'b1;
                grow_next   = 1'b0;
            end else if (low_lat_reg && s_relaxed_priority) begin
                grow_next   = 1'b1;
                shrink_next = 1'b0;
            end
        end else if (s_accept && (depth_reg == '0)) begin
            s1_valid_next = 1'b1;
            s1_src_next   = sddl_pkg::SRC_WORD;
            s1_word_next  = s_rec;
        end else if (sample_go) begin
            shrink_next   = 1'b0;
            grow_next     = 1'b0;
            mem_rd_en     = 1'b1;
            mem_wr_en     = 1'b1;
            s1_valid_next = 1'b1;
            if (pad_hit) begin
                s1_src_next    = sddl_pkg::SRC_WORD;
                s1_word_next   = pad_rec_b;
                pad_start_next = pad_start_b + sddl_pkg::IDX_W'(1);
                pad_len_next   = pad_len_b - sddl_pkg::CNT_W'(1);
            end else begin
                s1_src_next    = slot_valid_reg[oldest_a] ? sddl_pkg::SRC_MEM
                                                          : sddl_pkg::SRC_ZERO;
                pad_start_next = pad_start_b;
                pad_len_next   = pad_len_b;
            end
            pad_rec_next                 = pad_rec_b;
            slot_valid_next[mem_wr_addr] = 1'b1;
            oldest_next                  = oldest_a + sddl_pkg::IDX_W'(1);
            count_next                   = count_b;
        end
    end

    // read-first: a read and a write of the same slot return the old record
    always_ff @(posedge aclk) begin
        if (mem_wr_en) begin
            ring_mem[mem_wr_addr] <= s_rec;
        end
        if (mem_rd_en) begin
            rd_data_reg <= ring_mem[mem_rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            depth_reg      <= '0;
            oldest_reg     <= '0;
            count_reg      <= '0;
            low_lat_reg    <= 1'b0;
            shrink_reg     <= 1'b0;
            grow_reg       <= 1'b0;
            slot_valid_reg <= '0;
            pad_start_reg  <= '0;
            pad_len_reg    <= '0;
            s1_valid_reg   <= 1'b0;
            s1_src_reg     <= sddl_pkg::SRC_ZERO;
            m_valid_reg    <= 1'b0;
        end else begin
            depth_reg      <= depth_next;
            oldest_reg     <= oldest_next;
            count_reg      <= count_next;
            low_lat_reg    <= low_lat_next;
            shrink_reg     <= shrink_next;
            grow_reg       <= grow_next;
            slot_valid_reg <= slot_valid_next;
            pad_start_reg  <= pad_start_next;
            pad_len_reg    <= pad_len_next;
            s1_valid_reg   <= s1_valid_next;
            s1_src_reg     <= s1_src_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        pad_rec_reg <= pad_rec_next;
        s1_word_reg <= s1_word_next;
        m_rec_reg   <= m_rec_next;
    end

    assign m_valid            = m_valid_reg;
    assign m_delayed_position = m_rec_reg.position;
    assign m_delayed_velocity = m_rec_reg.velocity;
    assign m_delayed_effort   = m_rec_reg.effort;

`ifndef NO_ASSERTIONS
    a_count_le_depth: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= sddl_pkg::CNT_W'(depth_reg))
        else $error("entry count exceeds depth");

    a_pad_in_store: assert property (@(posedge aclk) disable iff (!aresetn)
        pad_len_reg <= count_reg)
        else $error("pad segment longer than store");

    a_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        (depth_reg != '0) |-> (count_reg != '0))
        else $error("empty store with nonzero depth");

    // a ring read waiting in the read stage is held while the output stalls
    a_read_held: assert property (@(posedge aclk) disable iff (!aresetn)
        (s1_valid_reg && (s1_src_reg == sddl_pkg::SRC_MEM) && !out_free)
        |=> $stable(rd_data_reg))
        else $error("ring read data lost while stalled");
`endif

endmodule

// ===== sim/switchable_depth_delay_line_tb.sv =====
`timescale 1ns / 100ps
// switchable_depth_delay_line_tb: self-checking testbench of the switchable depth delay line
// depends on sddl_pkg and switchable_depth_delay_line; predicts every delayed record in place
module switchable_depth_delay_line_tb;
    import sddl_pkg::*;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  cfg_wr_en = 1'b0;
    logic [DEPTH_BITS-1:0] cfg_wr_data = '0;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    logic                  s_operation = OP_SAMPLE;
    logic                  s_relaxed_priority = 1'b0;
    logic [WORD_BITS-1:0]  s_position_word = '0;
    logic [WORD_BITS-1:0]  s_velocity_word = '0;
    logic [WORD_BITS-1:0]  s_effort_word = '0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    logic [WORD_BITS-1:0]  m_delayed_position;
    logic [WORD_BITS-1:0]  m_delayed_velocity;
    logic [WORD_BITS-1:0]  m_delayed_effort;

    // predicted delay line state
    record_t               ring_copy [MAX_DEPTH];
    logic [IDX_W-1:0]      oldest = '0;
    logic [CNT_W-1:0]      held = '0;
    logic [DEPTH_BITS-1:0] depth_now = '0;
    logic                  fast_mode = 1'b0;
    logic                  shrink_due = 1'b0;
    logic                  grow_due = 1'b0;

    record_t               due_records [$];
    int                    mismatch_count = 0;
    bit                    steady = 1'b0;

    switchable_depth_delay_line DUT (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cfg_wr_en          (cfg_wr_en),
        .cfg_wr_data        (cfg_wr_data),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_operation        (s_operation),
        .s_relaxed_priority (s_relaxed_priority),
        .s_position_word    (s_position_word),
        .s_velocity_word    (s_velocity_word),
        .s_effort_word      (s_effort_word),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_delayed_position (m_delayed_position),
        .m_delayed_velocity (m_delayed_velocity),
        .m_delayed_effort   (m_delayed_effort)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        m_ready <= steady || ($urandom_range(99) >= 18);
    end

    function automatic record_t random_record();
        record_t rec;
        rec.position = {$urandom, $urandom};
        rec.velocity = {$urandom, $urandom};
        rec.effort   = {$urandom, $urandom};
        return rec;
    endfunction

    function automatic void apply_depth_write(input logic [DEPTH_BITS-1:0] value);
        depth_now = (value > MAX_DEPTH) ? DEPTH_BITS'(MAX_DEPTH) : value;
        foreach (ring_copy[i]) ring_copy[i] = '0;
        oldest = '0;
        held   = CNT_W'(depth_now);
    endfunction

    // advances the predicted ring by one accepted item, queues the delayed record if any
    function automatic void delay_line_step(input logic op, input logic relaxed,
                                            input record_t rec);
        logic was_low;
        if (op == OP_PRIORITY) begin
            was_low   = fast_mode;
            fast_mode = !relaxed;
            if (!was_low && fast_mode) begin
                shrink_due = 1'b1;
                grow_due   = 1'b0;
            end else if (was_low && !fast_mode) begin
                grow_due   = 1'b1;
                shrink_due = 1'b0;
            end
            return;
        end
        if (depth_now == 0) begin
            due_records.push_back(rec);
            return;
        end
        if (shrink_due) begin
            shrink_due = 1'b0;
            if (held > 1) begin
                oldest = oldest + IDX_W'(held - 1);
                held   = CNT_W'(1);
            end
        end
        if (grow_due) begin
            grow_due = 1'b0;
            // pad the back with copies of this sample
            for (int i = held; i < depth_now; i++) ring_copy[oldest + IDX_W'(i)] = rec;
            held = depth_now;
        end
        if (held == 0) begin
            due_records.push_back(rec);
        end else begin
            due_records.push_back(ring_copy[oldest]);
            // a full ring wraps onto the slot just read
            ring_copy[IDX_W'(oldest + IDX_W'(held))] = rec;
            oldest = oldest + 1'b1;
        end
    endfunction

    task automatic offer_item(input logic op, input logic relaxed, input record_t rec);
        while (!steady && $urandom_range(99) < 18) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid            <= 1'b1;
        s_operation        <= op;
        s_relaxed_priority <= relaxed;
        s_position_word    <= rec.position;
        s_velocity_word    <= rec.velocity;
        s_effort_word      <= rec.effort;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        delay_line_step(op, relaxed, rec);
    endtask

    // wait for every due record, then let a trailing priority item finish
    task automatic settle();
        s_valid <= 1'b0;
        while (due_records.size() != 0) @(posedge aclk);
        repeat (6) @(posedge aclk);
    endtask

    task automatic program_depth(input logic [DEPTH_BITS-1:0] value);
        settle();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        apply_depth_write(value);
    endtask

    task automatic note_mismatch(input string what, input logic [WORD_BITS-1:0] want,
                                 input logic [WORD_BITS-1:0] got);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("%0t: %s expected %h got %h", $time, what, want, got);
    endtask

    always @(posedge aclk) begin : check_results
        record_t got;
        record_t want;
        if (aresetn && m_valid && m_ready) begin
            got = {m_delayed_position, m_delayed_velocity, m_delayed_effort};
            if (due_records.size() == 0) begin
                note_mismatch("unexpected item, position", '0, got.position);
            end else begin
                want = due_records[0];
                due_records.delete(0);
                if (got.position !== want.position)
                    note_mismatch("position", want.position, got.position);
                if (got.velocity !== want.velocity)
                    note_mismatch("velocity", want.velocity, got.velocity);
                if (got.effort !== want.effort)
                    note_mismatch("effort", want.effort, got.effort);
            end
        end
    end

    // depth 0 after reset: samples pass through, low latency request stays armed
    task automatic test_passthrough();
        offer_item(OP_SAMPLE, 1'b0, '{64'h0, 64'h0, 64'h0});
        offer_item(OP_SAMPLE, 1'b1, '{'1, '1, '1});
        offer_item(OP_SAMPLE, 1'b0, '{64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555,
                                      64'h0123_4567_89AB_CDEF});
        offer_item(OP_PRIORITY, 1'b0, random_record());
        offer_item(OP_PRIORITY, 1'b0, random_record());
    endtask

    // shrink armed in bypass lands on the first sample after a depth write, then a grow
    task automatic test_held_shrink();
        program_depth(4);
        repeat (2) offer_item(OP_SAMPLE, 1'b0, random_record());
        offer_item(OP_PRIORITY, 1'b1, random_record());
        repeat (4) offer_item(OP_SAMPLE, 1'b1, random_record());
    endtask

    // shrink of a single record, then a grow with the store already at depth
    task automatic test_short_shrink();
        program_depth(1);
        offer_item(OP_PRIORITY, 1'b0, random_record());
        offer_item(OP_SAMPLE, 1'b0, random_record());
        offer_item(OP_PRIORITY, 1'b1, random_record());
        offer_item(OP_SAMPLE, 1'b0, random_record());
    endtask

    // a return to normal latency before any sample cancels the shrink
    task automatic test_cancelled_shrink();
        program_depth(3);
        offer_item(OP_PRIORITY, 1'b0, random_record());
        offer_item(OP_PRIORITY, 1'b1, random_record());
        repeat (2) offer_item(OP_SAMPLE, 1'b0, random_record());
    endtask

    // oversized depth saturates to capacity, then a shrink of the full ring
    task automatic test_full_capacity();
        program_depth('1);
        offer_item(OP_SAMPLE, 1'b0, random_record());
        offer_item(OP_PRIORITY, 1'b0, random_record());
        repeat (2) offer_item(OP_SAMPLE, 1'b0, random_record());
    endtask

    task automatic test_random_traffic();
        logic [DEPTH_BITS-1:0] depth_plan [12];
        depth_plan = '{0, 1, 2, 3, 5, 8, 16, 256, 511, 0, 0, 4};
        depth_plan[9]  = DEPTH_BITS'($urandom_range(1, 32));
        depth_plan[10] = DEPTH_BITS'($urandom_range(0, 511));
        for (int ph = 0; ph < 12; ph++) begin
            program_depth(depth_plan[ph]);
            steady = (ph == 5);
            repeat (112) begin
                if ($urandom_range(99) < 12)
                    offer_item(OP_PRIORITY, 1'($urandom), random_record());
                else
                    offer_item(OP_SAMPLE, 1'($urandom), random_record());
            end
        end
        steady = 1'b0;
    endtask

    initial begin
        foreach (ring_copy[i]) ring_copy[i] = '0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        test_passthrough();
        test_held_shrink();
        test_short_shrink();
        test_cancelled_shrink();
        test_full_capacity();
        test_random_traffic();
        settle();
        if (mismatch_count == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule

// ===== sim.f =====
design/sddl_pkg.sv
design/switchable_depth_delay_line.sv
sim/switchable_depth_delay_line_tb.sv
